// ===== hdl/lnt_pkg.sv =====
// Shared types and constants for the C lexical nesting tracker.
// Holds the beat structs, lexer state codes, error codes and character codes.
// No dependencies.
`default_nettype none

package lnt_pkg;

	// Default width of the nesting counter
	localparam int NEST_WIDTH_DEF = 8;

	// Width of the depth field in a result beat
	localparam int DEPTH_OUT_W = 8;

	// Item actions
	localparam logic ACT_SCAN    = 1'b0;
	localparam logic ACT_RESTART = 1'b1;

	// Lexer states
	typedef enum logic [2:0] {
		LEX_NORMAL = 3'd0,
		LEX_STRING = 3'd1,
		LEX_CHAR   = 3'd2,
		LEX_SLASH  = 3'd3,
		LEX_BLOCK  = 3'd4,
		LEX_LINE   = 3'd5
	} lex_state_t;

	// Error codes
	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_CLOSER  = 2'd1,
		ERR_NEWLINE = 2'd2
	} err_code_t;

	// Character codes
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_LBRACK  = 8'h5B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_RBRACK  = 8'h5D;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;

	// Input beat
	typedef struct packed {
		logic       action;
		logic [7:0] byte_value;
		logic [7:0] start_nesting;
		logic       chunk_last;
	} in_item_t;

	// Result beat
	typedef struct packed {
		logic [DEPTH_OUT_W-1:0] nesting_depth;
		lex_state_t             lex_state;
		logic                   at_top_level;
		err_code_t              error_code;
		logic                   chunk_end;
	} out_item_t;

	// Lexer flags carried between the state registers and the next-state logic
	typedef struct packed {
		lex_state_t state;
		logic       escape;
		logic       star;
	} lex_flags_t;

endpackage

`default_nettype wire

// ===== hdl/c_lexical_nesting_tracker_unit.sv =====
// Bracket nesting tracker for C/C++ source, one byte per beat.
// Latency: a result beat is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle while result_ready holds; the result register drains while the next item enters.
// Reset: clears the lexer to normal code, depth zero, flags clear, no result pending.
// Depends on lnt_pkg and lnt_next.
`default_nettype none

module c_lexical_nesting_tracker_unit import lnt_pkg::*; #(
	parameter int NEST_WIDTH = NEST_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	output logic       item_ready,
	input  in_item_t   item,
	output logic       result_valid,
	input  wire        result_ready,
	output out_item_t  result
);

	lex_flags_t            flags_q;
	logic [NEST_WIDTH-1:0] depth_q;
	lex_flags_t            nxt_flags;
	logic [NEST_WIDTH-1:0] nxt_depth;
	out_item_t             nxt_result;
	out_item_t             result_q;
	logic                  result_valid_q;
	logic                  item_fire;

	// Take a new item whenever the result register is empty or draining
	assign item_ready = !result_valid_q || result_ready;
	assign item_fire  = item_valid && item_ready;

	lnt_next #(
		.NEST_WIDTH(NEST_WIDTH)
	) u_next (
		.item      (item),
		.cur_flags (flags_q),
		.cur_depth (depth_q),
		.nxt_flags (nxt_flags),
		.nxt_depth (nxt_depth),
		.result    (nxt_result)
	);

	// Hold lexer state; advance it on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q.state  <= LEX_NORMAL;
			flags_q.escape <= 1'b0;
			flags_q.star   <= 1'b0;
			depth_q        <= '0;
		end else if (item_fire) begin
			flags_q <= nxt_flags;
			depth_q <= nxt_depth;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (item_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (item_fire) begin
			result_q <= nxt_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

// ===== hdl/lnt_next.sv =====
// Next-state and result logic for one beat of the nesting tracker.
// Purely combinational; depends on lnt_pkg.
`default_nettype none

module lnt_next import lnt_pkg::*; #(
	parameter int NEST_WIDTH = NEST_WIDTH_DEF
) (
	input  in_item_t              item,
	input  lex_flags_t            cur_flags,
	input  logic [NEST_WIDTH-1:0] cur_depth,
	output lex_flags_t            nxt_flags,
	output logic [NEST_WIDTH-1:0] nxt_depth,
	output out_item_t             result
);

	// Common width for comparing the 8-bit start depth with the counter
	localparam int CMP_W = (NEST_WIDTH > DEPTH_OUT_W) ? NEST_WIDTH : DEPTH_OUT_W;
	localparam logic [NEST_WIDTH-1:0] DEPTH_MAX = {NEST_WIDTH{1'b1}};

	logic              as_normal;
	err_code_t         err;
	logic [CMP_W-1:0]  start_ext;
	logic [CMP_W-1:0]  max_ext;
	logic [CMP_W-1:0]  depth_ext;
	logic [7:0]        b;

	assign b         = item.byte_value;
	assign start_ext = CMP_W'(item.start_nesting);
	assign max_ext   = CMP_W'(DEPTH_MAX);

	// Advance the lexer by one byte, or restart it
	always_comb begin
		nxt_flags = cur_flags;
		nxt_depth = cur_depth;
		err       = ERR_NONE;
		as_normal = 1'b0;

		if (item.action == ACT_RESTART) begin
			nxt_flags.state  = LEX_NORMAL;
			nxt_flags.escape = 1'b0;
			nxt_flags.star   = 1'b0;
			nxt_depth = (start_ext > max_ext) ? DEPTH_MAX : NEST_WIDTH'(start_ext);
		end else begin
			case (cur_flags.state) inside
				LEX_STRING, LEX_CHAR: begin
					if (cur_flags.escape) begin
						nxt_flags.escape = 1'b0;
					end else if ((cur_flags.state == LEX_STRING && b == CH_DQUOTE) ||
					             (cur_flags.state == LEX_CHAR && b == CH_SQUOTE)) begin
						nxt_flags.state = LEX_NORMAL;
					end else if (b == CH_BSLASH) begin
						nxt_flags.escape = 1'b1;
					end else if (b == CH_NEWLINE) begin
						err = ERR_NEWLINE;
					end
				end
				LEX_SLASH: begin
					if (b == CH_STAR) begin
						nxt_flags.state = LEX_BLOCK;
						nxt_flags.star  = 1'b0;
					end else if (b == CH_SLASH) begin
						nxt_flags.state = LEX_LINE;
					end else begin
						as_normal = 1'b1;
					end
				end
				LEX_BLOCK: begin
					if (cur_flags.star && b == CH_SLASH) begin
						nxt_flags.state = LEX_NORMAL;
						nxt_flags.star  = 1'b0;
					end else begin
						nxt_flags.star = (b == CH_STAR);
					end
				end
				LEX_LINE: begin
					if (b == CH_NEWLINE) begin
						nxt_flags.state = LEX_NORMAL;
					end
				end
				default: begin
					as_normal = 1'b1;
				end
			endcase

			// Handle a byte of normal code: brackets, literal and comment openers
			if (as_normal) begin
				nxt_flags.state = LEX_NORMAL;
				case (b) inside
					CH_LBRACE, CH_LPAREN, CH_LBRACK: begin
						if (cur_depth != DEPTH_MAX) begin
							nxt_depth = cur_depth + NEST_WIDTH'(1);
						end
					end
					CH_RBRACE, CH_RPAREN, CH_RBRACK: begin
						if (cur_depth == '0) begin
							err = ERR_CLOSER;
						end else begin
							nxt_depth = cur_depth - NEST_WIDTH'(1);
						end
					end
					CH_DQUOTE: nxt_flags.state = LEX_STRING;
					CH_SQUOTE: nxt_flags.state = LEX_CHAR;
					CH_SLASH:  nxt_flags.state = LEX_SLASH;
					default: ;
				endcase
			end
		end
	end

	// Format the result beat from the updated state
	assign depth_ext = CMP_W'(nxt_depth);

	always_comb begin
		result.nesting_depth = depth_ext[DEPTH_OUT_W-1:0];
		result.lex_state     = nxt_flags.state;
		result.at_top_level  = (nxt_flags.state == LEX_NORMAL ||
		                        nxt_flags.state == LEX_SLASH) && (nxt_depth == '0);
		result.error_code    = err;
		result.chunk_end     = item.chunk_last;
	end

endmodule

`default_nettype wire

// ===== hdl/lnt_checker.sv =====
// Port-level assertions for c_lexical_nesting_tracker_unit, bound to the top level.
// Depends on lnt_pkg.
`default_nettype none

module lnt_checker import lnt_pkg::*; (
	input wire       clk,
	input wire       arst_n,
	input wire       item_valid,
	input wire       item_ready,
	input in_item_t  item,
	input wire       result_valid,
	input wire       result_ready,
	input out_item_t result
);

	// A stalled result beat holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// A restart beat yields a clean normal-state result next cycle
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.action == ACT_RESTART |=>
			result_valid && result.lex_state == LEX_NORMAL &&
			result.error_code == ERR_NONE)
		else $error("restart did not return to normal state");

	// Chunk marker travels with its beat
	a_chunk_echo: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid &&
			result.chunk_end == $past(item.chunk_last))
		else $error("chunk marker not echoed");

	// Top level implies zero depth
	a_top_depth: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.at_top_level |-> result.nesting_depth == '0)
		else $error("top level flagged with nonzero depth");

	// A stray closer only happens in normal code at depth zero
	a_closer_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.error_code == ERR_CLOSER |->
			result.nesting_depth == '0 && result.lex_state == LEX_NORMAL)
		else $error("closer error with nonzero depth or wrong state");

endmodule

bind c_lexical_nesting_tracker_unit lnt_checker u_lnt_checker (.*);

`default_nettype wire

// ===== dv/lnt_nesting_checker.sv =====
// Checker for the C lexical nesting tracker: watches both channels, predicts each result beat.
// Keeps its own lexer state and bracket depth and compares every result field in order.
// Depends on lnt_pkg.
`timescale 1ns / 1ps

module lnt_nesting_checker import lnt_pkg::*; #(
	parameter int NEST_WIDTH = NEST_WIDTH_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        item_valid,
	input  wire        item_ready,
	input  in_item_t   item,
	input  wire        result_valid,
	input  wire        result_ready,
	input  out_item_t  result,
	output int         fail_count,
	output int         outstanding
);

	localparam logic [NEST_WIDTH-1:0] DEPTH_TOP = {NEST_WIDTH{1'b1}};

	// Shadow lexer state
	lex_state_t            lex_q;
	logic [NEST_WIDTH-1:0] nest_q;
	logic                  esc_q;
	logic                  star_q;

	out_item_t depth_reports_q[$];
	out_item_t want_beat;
	out_item_t next_beat;
	int        mismatches;

	// Apply one byte of plain code to the depth and state
	task automatic code_byte_effect(input logic [7:0] b, output err_code_t err);
		err = ERR_NONE;
		case (b)
			CH_LBRACE, CH_LPAREN, CH_LBRACK: begin
				if (nest_q != DEPTH_TOP)
					nest_q = nest_q + 1'b1;
			end
			CH_RBRACE, CH_RPAREN, CH_RBRACK: begin
				if (nest_q == '0)
					err = ERR_CLOSER;
				else
					nest_q = nest_q - 1'b1;
			end
			CH_DQUOTE: lex_q = LEX_STRING;
			CH_SQUOTE: lex_q = LEX_CHAR;
			CH_SLASH:  lex_q = LEX_SLASH;
			default: ;
		endcase
	endtask

	// Advance the shadow lexer by one item and form the result it should give
	task automatic lex_advance(input in_item_t it, output out_item_t res);
		err_code_t  err;
		logic [7:0] b;
		err = ERR_NONE;
		b = it.byte_value;
		if (it.action == ACT_RESTART) begin
			lex_q = LEX_NORMAL;
			esc_q = 1'b0;
			star_q = 1'b0;
			if (it.start_nesting > DEPTH_TOP)
				nest_q = DEPTH_TOP;
			else
				nest_q = it.start_nesting;
		end else begin
			case (lex_q)
				LEX_STRING, LEX_CHAR: begin
					if (esc_q)
						esc_q = 1'b0;
					else if ((lex_q == LEX_STRING && b == CH_DQUOTE) ||
						(lex_q == LEX_CHAR && b == CH_SQUOTE))
						lex_q = LEX_NORMAL;
					else if (b == CH_BSLASH)
						esc_q = 1'b1;
					else if (b == CH_NEWLINE)
						err = ERR_NEWLINE;
				end
				LEX_SLASH: begin
					if (b == CH_STAR) begin
						lex_q = LEX_BLOCK;
						star_q = 1'b0;
					end else if (b == CH_SLASH) begin
						lex_q = LEX_LINE;
					end else begin
						// a lone slash: the byte counts as plain code
						lex_q = LEX_NORMAL;
						code_byte_effect(b, err);
					end
				end
				LEX_BLOCK: begin
					if (star_q && b == CH_SLASH) begin
						lex_q = LEX_NORMAL;
						star_q = 1'b0;
					end else begin
						star_q = (b == CH_STAR);
					end
				end
				LEX_LINE: begin
					if (b == CH_NEWLINE)
						lex_q = LEX_NORMAL;
				end
				default: begin
					lex_q = LEX_NORMAL;
					code_byte_effect(b, err);
				end
			endcase
		end
		res.nesting_depth = nest_q;
		res.lex_state = lex_q;
		res.at_top_level = (lex_q == LEX_NORMAL || lex_q == LEX_SLASH) && nest_q == '0;
		res.error_code = err;
		res.chunk_end = it.chunk_last;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Retire result beats first, then record the prediction for the item beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lex_q = LEX_NORMAL;
			nest_q = '0;
			esc_q = 1'b0;
			star_q = 1'b0;
			depth_reports_q.delete();
			mismatches = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (depth_reports_q.size() == 0) begin
					$display("%0t: result beat with no expected result, actual %h", $time, result);
					mismatches++;
				end else begin
					want_beat = depth_reports_q.pop_front();
					check_field("nesting_depth", want_beat.nesting_depth, result.nesting_depth);
					check_field("lex_state", want_beat.lex_state, result.lex_state);
					check_field("at_top_level", want_beat.at_top_level, result.at_top_level);
					check_field("error_code", want_beat.error_code, result.error_code);
					check_field("chunk_end", want_beat.chunk_end, result.chunk_end);
				end
			end
			if (item_valid && item_ready) begin
				lex_advance(item, next_beat);
				depth_reports_q.push_back(next_beat);
			end
			fail_count <= mismatches;
			outstanding <= depth_reports_q.size();
		end
	end

endmodule

// ===== dv/tb_c_lexical_nesting_tracker_unit.sv =====
// Testbench top for c_lexical_nesting_tracker_unit: drives source bytes and restarts.
// Builds C-like fragments with random idling and leaves checking to lnt_nesting_checker.
// Depends on lnt_pkg, lnt_nesting_checker and the block itself.
`timescale 1ns / 1ps

module tb_c_lexical_nesting_tracker_unit import lnt_pkg::*;;

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	int        fail_count;
	int        outstanding;
	bit        idle_on;
	bit        drained;
	int        items_sent;

	c_lexical_nesting_tracker_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	lnt_nesting_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the result side in random bursts while idling is on
	initial begin
		forever begin
			if (idle_on && $urandom_range(0, 4) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// Offer one item beat, hold it until accepted
	task automatic send_item(input in_item_t it);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		in_item_t it;
		it.action = ACT_SCAN;
		it.byte_value = b;
		it.start_nesting = 8'($urandom);
		it.chunk_last = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_restart(input logic [7:0] depth);
		in_item_t it;
		it.action = ACT_RESTART;
		it.byte_value = 8'($urandom);
		it.start_nesting = depth;
		it.chunk_last = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Drop valid and hold until every result beat has come back
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_code_byte();
		case ($urandom_range(0, 9))
			0: return CH_LPAREN;
			1: return CH_LBRACK;
			2: return CH_LBRACE;
			3: return CH_RPAREN;
			4: return CH_RBRACK;
			5: return CH_RBRACE;
			6: return CH_NEWLINE;
			7: return 8'h20;
			default: return 8'($urandom_range(8'h61, 8'h7a));
		endcase
	endfunction

	function automatic logic [7:0] pick_letter();
		return 8'($urandom_range(8'h61, 8'h7a));
	endfunction

	// Emit one mostly well-formed piece of C text, noise, or a restart
	task automatic emit_fragment();
		int         kind;
		logic [7:0] q;
		kind = $urandom_range(0, 99);
		if (kind < 30) begin
			repeat ($urandom_range(1, 8)) send_byte(pick_code_byte());
		end else if (kind < 55) begin
			// string or char literal with escapes and stray newlines
			q = (kind < 45) ? CH_DQUOTE : CH_SQUOTE;
			send_byte(q);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 9))
					0: begin
						send_byte(CH_BSLASH);
						send_byte(8'($urandom));
					end
					1: send_byte(CH_NEWLINE);
					2: send_byte(q == CH_DQUOTE ? CH_SQUOTE : CH_DQUOTE);
					3: send_byte(CH_LPAREN);
					default: send_byte(pick_letter());
				endcase
			end
			if ($urandom_range(0, 9) != 0)
				send_byte(q);
		end else if (kind < 67) begin
			// block comment with star runs
			send_byte(CH_SLASH);
			send_byte(CH_STAR);
			repeat ($urandom_range(0, 6)) begin
				case ($urandom_range(0, 4))
					0: send_byte(CH_STAR);
					1: send_byte(CH_SLASH);
					2: send_byte(CH_NEWLINE);
					3: send_byte(CH_RPAREN);
					default: send_byte(pick_letter());
				endcase
			end
			repeat ($urandom_range(1, 3)) send_byte(CH_STAR);
			if ($urandom_range(0, 9) != 0)
				send_byte(CH_SLASH);
		end else if (kind < 77) begin
			send_byte(CH_SLASH);
			send_byte(CH_SLASH);
			repeat ($urandom_range(0, 5)) send_byte($urandom_range(0, 1) ? CH_STAR : pick_code_byte());
			if ($urandom_range(0, 9) != 0)
				send_byte(CH_NEWLINE);
		end else if (kind < 85) begin
			send_byte(CH_SLASH);
			send_byte(pick_code_byte());
		end else if (kind < 93) begin
			send_byte(8'($urandom));
		end else begin
			case ($urandom_range(0, 4))
				0: send_restart(8'd0);
				1: send_restart(8'd255);
				2: send_restart(8'd254);
				3: send_restart(8'($urandom_range(0, 4)));
				default: send_restart(8'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		items_sent = 0;
		drained = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: saturation, closer at zero, literals, comments, lone slash
		send_restart(8'd255);
		send_byte(CH_LPAREN);
		send_restart(8'd0);
		send_byte(CH_RPAREN);
		send_byte(CH_LBRACK);
		send_byte(CH_RBRACE);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("\"\\\"\n\\\n\"");
		send_text("''");
		send_text("/(");
		send_text("/***/");
		send_text("//\n");

		// Random fragments; a quiet stretch midway and a quiet tail
		idle_on = 1'b1;
		while (items_sent < 1550) begin
			if (items_sent >= 1350 || (items_sent >= 700 && items_sent < 900))
				idle_on = 1'b0;
			else
				idle_on = 1'b1;
			if (items_sent >= 1000 && !drained) begin
				drain();
				drained = 1'b1;
			end
			emit_fragment();
		end

		drain();
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/lnt_pkg.sv
hdl/lnt_next.sv
hdl/c_lexical_nesting_tracker_unit.sv
hdl/lnt_checker.sv
dv/lnt_nesting_checker.sv
dv/tb_c_lexical_nesting_tracker_unit.sv
